// File: rtl/blsph_pkg.sv
// Package for the bar level smoother with peak hold.
// Holds field widths, register codes, reset values and the per-bar state record.
// No dependencies.
package blsph_pkg;

   localparam int BAR_W      = 4;
   localparam int LEVEL_W    = 16;
   localparam int HEIGHT_W   = 6;
   localparam int ROWS_W     = 8;
   localparam int Q16_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_BARS_DEFAULT     = 16;
   localparam int GRAPH_HEIGHT_DEFAULT = 44;

   localparam logic [LEVEL_W-1:0] FULL_Q14 = 16'd16384;
   localparam logic [Q16_W-1:0]   ONE_Q16  = 17'd65536;

   localparam logic                  TRACK_RESET      = 1'b1;
   localparam logic [LEVEL_W-1:0]    DECAY_STEP_RESET = 16'd328;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP   = 2'd1;

   typedef struct packed {
      logic [LEVEL_W-1:0] smoothed;
      logic [Q16_W-1:0]   peak;
      logic [Q16_W-1:0]   decay;
   } bar_state_type;

endpackage

// File: rtl/blsph_bar_store.sv
// Per-bar state store: smoothed level, held peak and decay accumulator.
// One read port and one write port, cleared at reset. Uses blsph_pkg.
module blsph_bar_store #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        rd_idx,
   output blsph_pkg::bar_state_type rd_entry,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  blsph_pkg::bar_state_type wr_entry
);
   import blsph_pkg::*;

   bar_state_type store_ff [DEPTH];

   assign rd_entry = store_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en) begin
         store_ff[wr_idx] <= wr_entry;
      end
   end

endmodule

// File: rtl/blsph_track_update.sv
// Smoothing, height scaling and peak/decay update for one bar.
// Purely combinational; uses blsph_pkg.
module blsph_track_update #(
   parameter int GRAPH_HEIGHT = 44
) (
   input  logic                           track,
   input  logic [blsph_pkg::LEVEL_W-1:0]  level,
   input  logic [blsph_pkg::LEVEL_W-1:0]  decay_step,
   input  blsph_pkg::bar_state_type       entry,
   output logic [blsph_pkg::ROWS_W-1:0]   height,
   output logic [blsph_pkg::Q16_W-1:0]    peak,
   output blsph_pkg::bar_state_type       next_entry
);
   import blsph_pkg::*;

   localparam logic [ROWS_W-1:0] GH8 = ROWS_W'(GRAPH_HEIGHT);

   typedef logic [255:0][Q16_W-1:0] nh_tab_type;

   // height in rows back to Q1.16, rounded up
   function automatic nh_tab_type nh_tab_f();
      nh_tab_type t;
      for (int h = 0; h < 256; h++) begin
         t[h] = Q16_W'(((h * 65536) + GRAPH_HEIGHT - 1) / GRAPH_HEIGHT);
      end
      return t;
   endfunction

   localparam nh_tab_type NH_TAB = nh_tab_f();

   logic [17:0]         sum3;
   logic [17:0]         sum_all;
   logic [LEVEL_W-1:0]  smoothed;
   logic [LEVEL_W-1:0]  v_sel;
   logic [14:0]         v_clamp;
   logic [22:0]         rows_prod;
   logic [Q16_W-1:0]    nh;
   logic [17:0]         d_sum;
   logic [Q16_W-1:0]    d_sat;
   logic [33:0]         sq_full;
   logic [Q16_W-1:0]    sq;
   logic [17:0]         nh_plus_sq;
   logic [Q16_W-1:0]    peak_fall;
   logic                beaten;

   always_comb begin
      sum3     = 18'({entry.smoothed, 1'b0}) + 18'(entry.smoothed);
      sum_all  = sum3 + 18'(level);
      smoothed = sum_all[17:2];

      v_sel   = track ? smoothed : level;
      v_clamp = (v_sel > FULL_Q14) ? FULL_Q14[14:0] : v_sel[14:0];
      rows_prod = 23'(v_clamp) * 23'(GH8);
      height    = rows_prod[21:14];

      nh = NH_TAB[height];

      // grow the decay, saturate at 1.0, square it
      d_sum   = 18'(entry.decay) + 18'(decay_step);
      d_sat   = (d_sum > 18'(ONE_Q16)) ? ONE_Q16 : d_sum[Q16_W-1:0];
      sq_full = 34'(d_sat) * 34'(d_sat);
      sq      = sq_full[32:16];

      nh_plus_sq = 18'(nh) + 18'(sq);
      peak_fall  = (18'(entry.peak) > nh_plus_sq) ? (entry.peak - sq) : nh;

      beaten = nh > entry.peak;
      peak   = beaten ? nh : peak_fall;

      next_entry.smoothed = smoothed;
      next_entry.peak     = peak;
      next_entry.decay    = beaten ? '0 : d_sat;
   end

endmodule

// File: rtl/blsph_peak_scale.sv
// Scales the held Q1.16 peak to pixel rows and derives the visibility flag.
// Purely combinational; uses blsph_pkg.
module blsph_peak_scale #(
   parameter int GRAPH_HEIGHT = 44
) (
   input  logic                           track,
   input  logic [blsph_pkg::Q16_W-1:0]    peak,
   output logic [blsph_pkg::HEIGHT_W-1:0] peak_height,
   output logic                           peak_shown
);
   import blsph_pkg::*;

   localparam logic [ROWS_W-1:0] GH8 = ROWS_W'(GRAPH_HEIGHT);

   logic [24:0] prod;

   always_comb begin
      prod        = 25'(peak) * 25'(GH8);
      peak_height = track ? prod[16 +: HEIGHT_W] : '0;
      peak_shown  = track && (peak != '0);
   end

endmodule

// File: rtl/bar_level_smooth_peak_hold.sv
// Bar level smoother with decaying peak hold.
// A request passes through input, mid and output registers before its response appears.
// Throughput: one request per cycle while rsp_ready does not stall the pipeline, set by
// the read-modify-write of the per-bar state in the stage after input.
// Reset: pipeline emptied, all bar state cleared at once, registers to defaults.
module bar_level_smooth_peak_hold #(
   parameter int NUM_BARS     = blsph_pkg::NUM_BARS_DEFAULT,
   parameter int GRAPH_HEIGHT = blsph_pkg::GRAPH_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [blsph_pkg::BAR_W-1:0]      req_bar,
   input  logic [blsph_pkg::LEVEL_W-1:0]    req_level,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [blsph_pkg::BAR_W-1:0]      rsp_bar_out,
   output logic [blsph_pkg::HEIGHT_W-1:0]   rsp_bar_height,
   output logic [blsph_pkg::HEIGHT_W-1:0]   rsp_peak_height,
   output logic                             rsp_peak_shown,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [blsph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blsph_pkg::CSR_DATA_W-1:0] csr_data
);
   import blsph_pkg::*;

   // only the bars an index can reach get storage
   localparam int STORE_DEPTH = (NUM_BARS < (1 << BAR_W)) ? NUM_BARS : (1 << BAR_W);
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // configuration registers
   logic                track_en_ff;
   logic [LEVEL_W-1:0]  decay_step_ff;

   // input stage
   logic                in_valid_ff;
   logic [BAR_W-1:0]    in_bar_ff;
   logic [LEVEL_W-1:0]  in_level_ff;

   // mid stage
   logic                mid_valid_ff;
   logic [BAR_W-1:0]    mid_bar_ff;
   logic [ROWS_W-1:0]   mid_height_ff;
   logic [Q16_W-1:0]    mid_peak_ff;
   logic                mid_track_ff;

   // output stage
   logic                rsp_valid_ff;
   logic [BAR_W-1:0]    rsp_bar_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic [HEIGHT_W-1:0] rsp_peak_ff;
   logic                rsp_shown_ff;

   logic                out_en;
   logic                mid_en;
   logic                in_en;
   logic                in_track;
   logic [IDX_W-1:0]    in_idx;
   bar_state_type       rd_entry;
   bar_state_type       next_entry;
   logic [ROWS_W-1:0]   height;
   logic [Q16_W-1:0]    peak;
   logic [HEIGHT_W-1:0] peak_height;
   logic                peak_shown;

   // Advance each stage when the one after it has room or is moving on.
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign mid_en    = !mid_valid_ff || out_en;
   assign in_en     = !in_valid_ff || mid_en;
   assign req_ready = in_en;
   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         track_en_ff   <= TRACK_RESET;
         decay_step_ff <= DECAY_STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TRACK_ENABLE: track_en_ff   <= csr_data[0];
            CSR_DECAY_STEP:   decay_step_ff <= csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_valid) begin
         in_bar_ff   <= req_bar;
         in_level_ff <= req_level;
      end
   end

   // A bar beyond the store, or tracking off, passes the raw level through and
   // leaves the state untouched.
   assign in_track = track_en_ff && (32'(in_bar_ff) < 32'(NUM_BARS));
   assign in_idx   = in_bar_ff[IDX_W-1:0];

   blsph_bar_store #(
      .DEPTH (STORE_DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (in_idx),
      .rd_entry (rd_entry),
      .wr_en    (in_valid_ff && mid_en && in_track),
      .wr_idx   (in_idx),
      .wr_entry (next_entry)
   );

   // Read-modify-write of the bar: the entry is written as the request leaves the input stage,
   // so the next request for the same bar reads the updated entry without any forwarding.
   blsph_track_update #(
      .GRAPH_HEIGHT (GRAPH_HEIGHT)
   ) u_update (
      .track      (in_track),
      .level      (in_level_ff),
      .decay_step (decay_step_ff),
      .entry      (rd_entry),
      .height     (height),
      .peak       (peak),
      .next_entry (next_entry)
   );

   // Hold the bar height and the new peak for the scaling stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_en) begin
         mid_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_en && in_valid_ff) begin
         mid_bar_ff    <= in_bar_ff;
         mid_height_ff <= height;
         mid_peak_ff   <= peak;
         mid_track_ff  <= in_track;
      end
   end

   blsph_peak_scale #(
      .GRAPH_HEIGHT (GRAPH_HEIGHT)
   ) u_scale (
      .track       (mid_track_ff),
      .peak        (mid_peak_ff),
      .peak_height (peak_height),
      .peak_shown  (peak_shown)
   );

   // Output register; holds the response while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && mid_valid_ff) begin
         rsp_bar_ff    <= mid_bar_ff;
         rsp_height_ff <= mid_height_ff[HEIGHT_W-1:0];
         rsp_peak_ff   <= peak_height;
         rsp_shown_ff  <= peak_shown;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bar_out     = rsp_bar_ff;
   assign rsp_bar_height  = rsp_height_ff;
   assign rsp_peak_height = rsp_peak_ff;
   assign rsp_peak_shown  = rsp_shown_ff;

`ifndef SYNTHESIS
   // The held peak never rises above full scale.
   a_peak_bounded: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff |-> (mid_peak_ff <= ONE_Q16))
      else $error("held peak above full scale");

   // The stored decay accumulator never exceeds 1.0.
   a_decay_bounded: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (rd_entry.decay <= ONE_Q16))
      else $error("decay accumulator above full scale");

   // A hidden peak draws no rows.
   a_hidden_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_shown_ff) |-> (rsp_peak_ff == '0))
      else $error("peak rows drawn while peak hidden");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !mid_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for bar_level_smooth_peak_hold: directed table, then random phases.
// Predicts each bar reading from a private copy of the per-bar state and settings.
// Depends on rtl/blsph_pkg.sv and rtl/bar_level_smooth_peak_hold.sv.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import blsph_pkg::*;

   localparam int          BARS = NUM_BARS_DEFAULT;
   localparam int unsigned ROWS = GRAPH_HEIGHT_DEFAULT;

   // One reading as it leaves the response channel
   typedef struct packed {
      logic [BAR_W-1:0]    bar_out;
      logic [HEIGHT_W-1:0] bar_height;
      logic [HEIGHT_W-1:0] peak_height;
      logic                peak_shown;
   } meter_reading_type;

   // Directed script: either a level request or a new pair of settings
   typedef enum logic [1:0] {ROW_LEVEL, ROW_SETTINGS} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [BAR_W-1:0]    bar;
      logic [LEVEL_W-1:0]  level;
      logic                track;
      logic [LEVEL_W-1:0]  step;
      logic                typed;    // 1: reading below is the expectation
      meter_reading_type   reading;
   } script_row_type;

   // Hand-written readings only where they are obvious: straight after reset, and with
   // tracking off, where the height is the clamped raw level and the peak is blank.
   localparam int SCRIPT_LEN = 25;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{ROW_LEVEL,    4'd0,  16'd0,     1'b0, 16'd0,     1'b1, '{4'd0,  6'd0,  6'd0, 1'b0}},
      '{ROW_LEVEL,    4'd15, 16'd65535, 1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd65535, 1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd65535, 1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd0,     1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd0,     1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd1,  16'd16384, 1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd1,  16'd16385, 1'b0, 16'd0,     1'b0, '0},
      '{ROW_SETTINGS, 4'd0,  16'd0,     1'b1, 16'd65535, 1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd0,     1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd0,     1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd15, 16'd0,     1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd1,  16'd32768, 1'b0, 16'd0,     1'b0, '0},
      '{ROW_SETTINGS, 4'd0,  16'd0,     1'b1, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd7,  16'h5555,  1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd7,  16'hAAAA,  1'b0, 16'd0,     1'b0, '0},
      '{ROW_LEVEL,    4'd7,  16'd0,     1'b0, 16'd0,     1'b0, '0},
      '{ROW_SETTINGS, 4'd0,  16'd0,     1'b0, 16'd1,     1'b0, '0},
      '{ROW_LEVEL,    4'd3,  16'd65535, 1'b0, 16'd0,     1'b1, '{4'd3,  6'd44, 6'd0, 1'b0}},
      '{ROW_LEVEL,    4'd4,  16'd16384, 1'b0, 16'd0,     1'b1, '{4'd4,  6'd44, 6'd0, 1'b0}},
      '{ROW_LEVEL,    4'd5,  16'd16383, 1'b0, 16'd0,     1'b1, '{4'd5,  6'd43, 6'd0, 1'b0}},
      '{ROW_LEVEL,    4'd6,  16'd0,     1'b0, 16'd0,     1'b1, '{4'd6,  6'd0,  6'd0, 1'b0}},
      '{ROW_LEVEL,    4'd15, 16'd65535, 1'b0, 16'd0,     1'b1, '{4'd15, 6'd44, 6'd0, 1'b0}},
      '{ROW_SETTINGS, 4'd0,  16'd0,     1'b1, 16'd328,   1'b0, '0},
      // bar 15 must pick up where it was before tracking went off
      '{ROW_LEVEL,    4'd15, 16'd0,     1'b0, 16'd0,     1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BAR_W-1:0]      req_bar = '0;
   logic [LEVEL_W-1:0]    req_level = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BAR_W-1:0]      rsp_bar_out;
   logic [HEIGHT_W-1:0]   rsp_bar_height;
   logic [HEIGHT_W-1:0]   rsp_peak_height;
   logic                  rsp_peak_shown;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Private copy of the per-bar state and the settings
   logic [LEVEL_W-1:0] smooth_mem [BARS] = '{default: '0};
   logic [Q16_W-1:0]   peak_mem   [BARS] = '{default: '0};
   logic [Q16_W-1:0]   decay_mem  [BARS] = '{default: '0};
   logic               track_en = TRACK_RESET;
   logic [LEVEL_W-1:0] step_q16 = DECAY_STEP_RESET;

   meter_reading_type pending_readings [$];
   int                mismatch_count = 0;
   bit                idling_on = 1'b1;
   int                rsp_stall_left = 0;

   bar_level_smooth_peak_hold #(
      .NUM_BARS     (BARS),
      .GRAPH_HEIGHT (ROWS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_bar         (req_bar),
      .req_level       (req_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bar_out     (rsp_bar_out),
      .rsp_bar_height  (rsp_bar_height),
      .rsp_peak_height (rsp_peak_height),
      .rsp_peak_shown  (rsp_peak_shown),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   // Clamp a Q2.14 level to full scale and scale it to pixel rows
   function automatic int unsigned rows_of(input int unsigned v);
      int unsigned clamped;
      clamped = (v > 32'(FULL_Q14)) ? 32'(FULL_Q14) : v;
      return (clamped * ROWS) >> 14;
   endfunction

   // Advance one bar of the meter by one level and return the reading it gives
   function automatic meter_reading_type advance_meter(input logic [BAR_W-1:0] bar,
                                                       input logic [LEVEL_W-1:0] level);
      meter_reading_type r;
      int unsigned       s, height, nh, pk, d, sq;
      r = '0;
      r.bar_out = bar;
      if (track_en && int'(bar) < BARS) begin
         // smooth: three quarters old, one quarter new, truncated
         s = (3 * 32'(smooth_mem[bar]) + 32'(level)) >> 2;
         smooth_mem[bar] = LEVEL_W'(s);
         height = rows_of(s);
         // height back to Q1.16, rounded up so a fresh peak maps to the same row
         nh = ((height << 16) + ROWS - 1) / ROWS;
         pk = 32'(peak_mem[bar]);
         if (nh > pk) begin
            pk = nh;
            d = 0;
         end else begin
            d = 32'(decay_mem[bar]) + 32'(step_q16);
            if (d > 32'(ONE_Q16))
               d = 32'(ONE_Q16);
            sq = 32'((64'(d) * 64'(d)) >> 16);
            pk = (pk > nh + sq) ? pk - sq : nh;
         end
         if (pk > 32'(ONE_Q16))
            pk = 32'(ONE_Q16);
         peak_mem[bar]  = Q16_W'(pk);
         decay_mem[bar] = Q16_W'(d);
         r.bar_height  = HEIGHT_W'(height);
         r.peak_height = HEIGHT_W'((pk * ROWS) >> 16);
         r.peak_shown  = (pk != 0);
      end else begin
         // untracked: raw level straight to rows, peak blank, state untouched
         r.bar_height = HEIGHT_W'(rows_of(32'(level)));
      end
      return r;
   endfunction

   // Offer one level request; hold it until taken, then note the reading it should give.
   // Returns at the falling edge after acceptance with valid still high.
   task automatic send_level(input logic [BAR_W-1:0] bar, input logic [LEVEL_W-1:0] level,
                             input logic typed, input meter_reading_type typed_reading);
      meter_reading_type predicted;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_bar   <= bar;
      req_level <= level;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // always run the predictor so the private state keeps step with the block
      predicted = advance_meter(bar, level);
      pending_readings.push_back(typed ? typed_reading : predicted);
      @(negedge clock);
   endtask

   // Write both registers once the block has drained. Each request gives a reading,
   // so an empty queue means the pipeline is idle.
   task automatic apply_settings(input logic track, input logic [LEVEL_W-1:0] step);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_TRACK_ENABLE;
      csr_data  <= CSR_DATA_W'(track);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      track_en = track;
      @(negedge clock);
      csr_index <= CSR_DECAY_STEP;
      csr_data  <= step;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      step_q16 = step;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Response stalls: random bursts of rsp_ready low, none started while idling is off
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted reading with the oldest one outstanding
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected reading, expected none, actual bar %0d height %0d peak %0d",
                     $time, rsp_bar_out, rsp_bar_height, rsp_peak_height);
         end else begin
            want = pending_readings.pop_front();
            check_field("bar_out",     want.bar_out,     rsp_bar_out);
            check_field("bar_height",  want.bar_height,  rsp_bar_height);
            check_field("peak_height", want.peak_height, rsp_peak_height);
            check_field("peak_shown",  want.peak_shown,  rsp_peak_shown);
         end
      end
   end

   initial begin
      int                 row, phase, sent, rise, fall, k;
      logic [BAR_W-1:0]   bar;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] step;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script
      for (row = 0; row < SCRIPT_LEN; row++) begin
         if (SCRIPT[row].kind == ROW_SETTINGS)
            apply_settings(SCRIPT[row].track, SCRIPT[row].step);
         else
            send_level(SCRIPT[row].bar, SCRIPT[row].level, SCRIPT[row].typed,
                       SCRIPT[row].reading);
      end

      // Random phases, each under its own settings; the last two run without idling
      for (phase = 0; phase < 12; phase++) begin
         idling_on = (phase < 10) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 4))
            0:       step = '0;
            1:       step = '1;
            2:       step = DECAY_STEP_RESET;
            3:       step = LEVEL_W'($urandom_range(1, 2000));
            default: step = LEVEL_W'($urandom_range(0, 65535));
         endcase
         apply_settings($urandom_range(0, 4) != 0, step);
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(0, 9) < 7) begin
               // a hit on one bar: a few loud levels, then a tail of quiet ones so the
               // held peak has time to fall
               bar  = BAR_W'($urandom_range(0, BARS - 1));
               rise = $urandom_range(1, 4);
               fall = $urandom_range(1, 24);
               for (k = 0; k < rise + fall; k++) begin
                  level = (k < rise) ? LEVEL_W'($urandom_range(8192, 65535))
                                     : LEVEL_W'($urandom_range(0, 3000));
                  send_level(bar, level, 1'b0, '0);
               end
               sent += rise + fall;
            end else begin
               send_level(BAR_W'($urandom_range(0, BARS - 1)),
                          LEVEL_W'($urandom_range(0, 65535)), 1'b0, '0);
               sent++;
            end
         end
      end

      // Drain, then wait out anything stray
      req_valid <= 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timeout: %0d readings still outstanding", pending_readings.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/blsph_pkg.sv
rtl/blsph_bar_store.sv
rtl/blsph_track_update.sv
rtl/blsph_peak_scale.sv
rtl/bar_level_smooth_peak_hold.sv
sim/tb.sv
